// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge once reset is released.
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// A condition that, when true, requires another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/pidv_pkg.sv =====
package pidv_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ERR_W     = 17;
    localparam int COEF_W    = 32;
    localparam int BAND_W    = 17;
    localparam int RUN_W     = 34;
    localparam int PROD_W    = COEF_W + ERR_W;
    localparam int SHIFT     = 8;
    localparam int TERM_W    = PROD_W - SHIFT;
    localparam int SUM3_W    = TERM_W + 2;
    localparam int ACC_W     = SUM3_W + 1;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ERR_W-1:0]    err_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic        [BAND_W-1:0]   band_t;
    typedef logic signed [RUN_W-1:0]    run_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM3_W-1:0]   sum3_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_COEF_NOW_FULL        = 3'd0;
    localparam cfg_idx_t REG_COEF_NOW_NO_INTEGRAL = 3'd1;
    localparam cfg_idx_t REG_COEF_PREV            = 3'd2;
    localparam cfg_idx_t REG_COEF_PREV_PREV       = 3'd3;
    localparam cfg_idx_t REG_OUT_MIN              = 3'd4;
    localparam cfg_idx_t REG_OUT_MAX              = 3'd5;
    localparam cfg_idx_t REG_INTEGRAL_BAND        = 3'd6;

    localparam coef_t OUT_MIN_RESET = 32'sd0;
    localparam coef_t OUT_MAX_RESET = 32'sd6553600;
    localparam band_t BAND_RESET    = 17'h1FFFF;

    typedef struct packed {
        coef_t coef_now_full;
        coef_t coef_now_no_integral;
        coef_t coef_prev;
        coef_t coef_prev_prev;
        coef_t out_min;
        coef_t out_max;
        band_t integral_band;
    } cfg_t;

endpackage

// ===== src/pidv_cfg.sv =====
module pidv_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  pidv_pkg::cfg_idx_t          cfg_index,
    input  logic [pidv_pkg::COEF_W-1:0] cfg_data,
    output pidv_pkg::cfg_t              cfg
);

    pidv_pkg::cfg_t  cfg_reg;
    pidv_pkg::coef_t wr_value;

    assign cfg_ready = 1'b1;
    assign wr_value  = $signed(cfg_data);
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_now_full        <= '0;
            cfg_reg.coef_now_no_integral <= '0;
            cfg_reg.coef_prev            <= '0;
            cfg_reg.coef_prev_prev       <= '0;
            cfg_reg.out_min              <= pidv_pkg::OUT_MIN_RESET;
            cfg_reg.out_max              <= pidv_pkg::OUT_MAX_RESET;
            cfg_reg.integral_band        <= pidv_pkg::BAND_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pidv_pkg::REG_COEF_NOW_FULL:        cfg_reg.coef_now_full <= wr_value;
                pidv_pkg::REG_COEF_NOW_NO_INTEGRAL: cfg_reg.coef_now_no_integral <= wr_value;
                pidv_pkg::REG_COEF_PREV:            cfg_reg.coef_prev <= wr_value;
                pidv_pkg::REG_COEF_PREV_PREV:       cfg_reg.coef_prev_prev <= wr_value;
                // Limit writes that would not leave out_min below out_max are dropped.
                pidv_pkg::REG_OUT_MIN: begin
                    if (wr_value < cfg_reg.out_max) begin
                        cfg_reg.out_min <= wr_value;
                    end
                end
                pidv_pkg::REG_OUT_MAX: begin
                    if (wr_value > cfg_reg.out_min) begin
                        cfg_reg.out_max <= wr_value;
                    end
                end
                pidv_pkg::REG_INTEGRAL_BAND: begin
                    cfg_reg.integral_band <= cfg_data[pidv_pkg::BAND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/pidv_core.sv =====
module pidv_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pidv_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pidv_pkg::sample_t    s_measured,
    input  pidv_pkg::sample_t    s_target,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pidv_pkg::coef_t      m_drive,
    output pidv_pkg::run_t       m_raw_output
);

    // Stage valid bits and the ready chain; a stage takes a beat when it is
    // empty or its own beat moves on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || m_ready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage 1: input samples.
    pidv_pkg::sample_t s1_measured_reg, s1_target_reg;

    // Stage 2: current error, error history and current-error weight.
    pidv_pkg::err_t  err_prev_reg, err_prev_prev_reg;
    pidv_pkg::err_t  s2_err_reg, s2_err1_reg, s2_err2_reg;
    pidv_pkg::coef_t s2_a0_reg;
    pidv_pkg::err_t  err_next;
    pidv_pkg::band_t err_mag;
    pidv_pkg::coef_t a0_next;

    // Stage 3: products. Stage 4: their shifted sum.
    pidv_pkg::prod_t s3_prod0_reg, s3_prod1_reg, s3_prod2_reg;
    pidv_pkg::sum3_t s4_sum_reg;
    pidv_pkg::sum3_t sum_next;

    // Stage 5: running output, which also serves as that stage's payload.
    pidv_pkg::run_t  running_reg;
    pidv_pkg::run_t  bound_hi_reg, bound_lo_reg;
    pidv_pkg::acc_t  acc_next;
    pidv_pkg::run_t  running_next;

    // Stage 6: result register.
    pidv_pkg::coef_t drive_reg;
    pidv_pkg::run_t  raw_reg;
    pidv_pkg::coef_t drive_next;

    always_comb begin
        err_next = pidv_pkg::err_t'(s1_target_reg) - pidv_pkg::err_t'(s1_measured_reg);
        err_mag  = err_next[pidv_pkg::ERR_W-1] ? pidv_pkg::band_t'(-err_next)
                                               : pidv_pkg::band_t'(err_next);
        // At or above the band the integral part of the weight is dropped.
        a0_next  = (err_mag < cfg.integral_band) ? cfg.coef_now_full
                                                 : cfg.coef_now_no_integral;
    end

    always_comb begin
        sum_next =
            pidv_pkg::sum3_t'($signed(s3_prod0_reg[pidv_pkg::PROD_W-1:pidv_pkg::SHIFT]))
          + pidv_pkg::sum3_t'($signed(s3_prod1_reg[pidv_pkg::PROD_W-1:pidv_pkg::SHIFT]))
          + pidv_pkg::sum3_t'($signed(s3_prod2_reg[pidv_pkg::PROD_W-1:pidv_pkg::SHIFT]));
    end

    always_comb begin
        acc_next = pidv_pkg::acc_t'(running_reg) + pidv_pkg::acc_t'(s4_sum_reg);
        priority if (acc_next > pidv_pkg::acc_t'(bound_hi_reg)) begin
            running_next = bound_hi_reg;
        end else if (acc_next < pidv_pkg::acc_t'(bound_lo_reg)) begin
            running_next = bound_lo_reg;
        end else begin
            running_next = pidv_pkg::run_t'(acc_next);
        end
    end

    always_comb begin
        priority if (running_reg > pidv_pkg::run_t'(cfg.out_max)) begin
            drive_next = cfg.out_max;
        end else if (running_reg < pidv_pkg::run_t'(cfg.out_min)) begin
            drive_next = cfg.out_min;
        end else begin
            drive_next = pidv_pkg::coef_t'(running_reg);
        end
    end

    // The windup bound is registered from the limits. The user must change
    // limits only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        bound_hi_reg <= pidv_pkg::run_t'(cfg.out_max) + pidv_pkg::run_t'(cfg.out_max)
                      - pidv_pkg::run_t'(cfg.out_min);
        bound_lo_reg <= pidv_pkg::run_t'(cfg.out_min) + pidv_pkg::run_t'(cfg.out_min)
                      - pidv_pkg::run_t'(cfg.out_max);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
            v5_reg            <= 1'b0;
            v6_reg            <= 1'b0;
            err_prev_reg      <= '0;
            err_prev_prev_reg <= '0;
            running_reg       <= '0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
            if (v1_reg && rdy2) begin
                err_prev_reg      <= err_next;
                err_prev_prev_reg <= err_prev_reg;
            end
            if (v4_reg && rdy5) begin
                running_reg <= running_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy1) begin
            s1_measured_reg <= s_measured;
            s1_target_reg   <= s_target;
        end
        if (v1_reg && rdy2) begin
            s2_err_reg  <= err_next;
            s2_err1_reg <= err_prev_reg;
            s2_err2_reg <= err_prev_prev_reg;
            s2_a0_reg   <= a0_next;
        end
        if (v2_reg && rdy3) begin
            s3_prod0_reg <= pidv_pkg::prod_t'(s2_a0_reg) * pidv_pkg::prod_t'(s2_err_reg);
            s3_prod1_reg <= pidv_pkg::prod_t'(cfg.coef_prev) * pidv_pkg::prod_t'(s2_err1_reg);
            s3_prod2_reg <= pidv_pkg::prod_t'(cfg.coef_prev_prev)
                          * pidv_pkg::prod_t'(s2_err2_reg);
        end
        if (v3_reg && rdy4) begin
            s4_sum_reg <= sum_next;
        end
        if (v5_reg && rdy6) begin
            drive_reg <= drive_next;
            raw_reg   <= running_reg;
        end
    end

    assign m_valid      = v6_reg;
    assign m_drive      = drive_reg;
    assign m_raw_output = raw_reg;

endmodule

// ===== src/pid_velocity_controller.sv =====
// Channel    Direction  Handshake               Payload
// s_         in         s_valid / s_ready       s_measured, s_target (Q8.8)
// m_         out        m_valid / m_ready       m_drive (Q16.16), m_raw_output (Q18.16)
// cfg_       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat is accepted per cycle unless a stall reaches the input. Beats pass the input,
// error, product, sum, running and result stages. The rate is set by the running-output
// accumulate and windup clamp. Reset (aresetn low, synchronous) empties the pipeline and
// clears error history, running output and registers to their defaults; cfg_ready is
// always high. A stalled result stalls only the stages behind it that are full.
`include "assert_macros.svh"

module pid_velocity_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [pidv_pkg::SAMPLE_W-1:0] s_measured,
    input  logic signed [pidv_pkg::SAMPLE_W-1:0] s_target,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [pidv_pkg::COEF_W-1:0]   m_drive,
    output logic signed [pidv_pkg::RUN_W-1:0]    m_raw_output,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pidv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pidv_pkg::COEF_W-1:0]    cfg_data
);

    pidv_pkg::cfg_t cfg;

    pidv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidv_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_measured   (s_measured),
        .s_target     (s_target),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_raw_output (m_raw_output)
    );

    `ASSERT_HOLDS(a_limits_ordered, cfg.out_min < cfg.out_max, "drive limits out of order")
    `ASSERT_IMPLIES(a_stall_source, !s_ready, m_valid && !m_ready, "input stall, output free")

endmodule
